// ===== design/smf_pkg.sv =====
// Shared types and defaults for the sliding median filter.
package smf_pkg;

	localparam int WINDOW_DEF       = 9;
	localparam int SAMPLE_WIDTH_DEF = 16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_UP,
		ST_CHK_DN,
		ST_UP,
		ST_UP_END,
		ST_DN,
		ST_DN_END,
		ST_MID,
		ST_CAP
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

// ===== design/smf_mem.sv =====
// Window store: one write port, one registered read port, zero until written.
module smf_mem #(
	parameter int WINDOW       = smf_pkg::WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH_DEF,
	localparam int IDX_W       = $clog2(WINDOW)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smf_pkg::mem_ctl_t       ctl,
	input  logic [IDX_W-1:0]        waddr,
	input  logic [SAMPLE_WIDTH-1:0] wdata,
	input  logic [IDX_W-1:0]        raddr,
	output logic [SAMPLE_WIDTH-1:0] rdata
);

	logic [SAMPLE_WIDTH-1:0] mem_q [WINDOW];
	logic [WINDOW-1:0]       written_q;
	logic [SAMPLE_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ctl.we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= written_q[raddr] ? mem_q[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/smf_ctrl.sv =====
// Insertion sequencer: neighbor test, compare-swap pass, median read and output register.
module smf_ctrl #(
	parameter int WINDOW       = smf_pkg::WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH_DEF,
	localparam int IDX_W       = $clog2(WINDOW)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] median,
	output smf_pkg::mem_ctl_t              mem_ctl,
	output logic [IDX_W-1:0]               mem_waddr,
	output logic [SAMPLE_WIDTH-1:0]        mem_wdata,
	output logic [IDX_W-1:0]               mem_raddr,
	input  logic [SAMPLE_WIDTH-1:0]        mem_rdata
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0] PEN  = IDX_W'(WINDOW - 2);
	localparam logic [IDX_W-1:0] MID  = IDX_W'(WINDOW / 2);
	localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);
	localparam logic [IDX_W-1:0] TWO  = IDX_W'(2);

	smf_pkg::state_t state_q, state_d;

	logic signed [SAMPLE_WIDTH-1:0] c_q, c_d;
	logic signed [SAMPLE_WIDTH-1:0] rd;
	logic signed [SAMPLE_WIDTH-1:0] median_q;
	logic [IDX_W-1:0]               k_q, k_d;
	logic [IDX_W-1:0]               slot_q, pos_q;
	logic                           out_valid_q;
	logic                           accept, up_gt, dn_lt, up_last, dn_last, cap;

	assign rd      = $signed(mem_rdata);
	assign accept  = in_valid && in_ready;
	assign up_gt   = c_q > rd;
	assign dn_lt   = rd > c_q;
	assign up_last = (k_q == PEN);
	assign dn_last = (k_q == ONE);
	assign cap     = (state_q == smf_pkg::ST_CAP) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			smf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (pos_q != LAST) ? smf_pkg::ST_CHK_UP : smf_pkg::ST_CHK_DN;
				end
			end
			smf_pkg::ST_CHK_UP: begin
				if (up_gt) begin
					state_d = up_last ? smf_pkg::ST_UP_END : smf_pkg::ST_UP;
				end else if (slot_q != '0) begin
					state_d = smf_pkg::ST_CHK_DN;
				end else begin
					state_d = smf_pkg::ST_MID;
				end
			end
			smf_pkg::ST_UP:     state_d = up_last ? smf_pkg::ST_UP_END : smf_pkg::ST_UP;
			smf_pkg::ST_UP_END: state_d = smf_pkg::ST_MID;
			smf_pkg::ST_CHK_DN: begin
				if (dn_lt) begin
					state_d = dn_last ? smf_pkg::ST_DN_END : smf_pkg::ST_DN;
				end else begin
					state_d = smf_pkg::ST_MID;
				end
			end
			smf_pkg::ST_DN:     state_d = dn_last ? smf_pkg::ST_DN_END : smf_pkg::ST_DN;
			smf_pkg::ST_DN_END: state_d = smf_pkg::ST_MID;
			smf_pkg::ST_MID:    state_d = smf_pkg::ST_CAP;
			smf_pkg::ST_CAP: begin
				if (!out_valid_q || out_ready) begin
					state_d = smf_pkg::ST_IDLE;
				end
			end
			default:            state_d = smf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		mem_ctl    = '0;
		mem_waddr  = k_q;
		mem_wdata  = c_q;
		mem_raddr  = k_q;
		c_d        = c_q;
		k_d        = k_q;
		case (state_q)
			smf_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				c_d        = sample;
				k_d        = pos_q;
				mem_ctl.re = in_valid;
				mem_raddr  = (pos_q != LAST) ? pos_q + ONE : pos_q - ONE;
			end
			smf_pkg::ST_CHK_UP, smf_pkg::ST_UP: begin
				if (up_gt || state_q == smf_pkg::ST_UP) begin
					mem_ctl.we = 1'b1;
					mem_wdata  = up_gt ? rd : c_q;
					c_d        = up_gt ? c_q : rd;
					k_d        = k_q + ONE;
					mem_ctl.re = !up_last;
					mem_raddr  = k_q + TWO;
				end else if (slot_q != '0) begin
					mem_ctl.re = 1'b1;
					mem_raddr  = slot_q - ONE;
				end else begin
					mem_ctl.we = 1'b1;
					mem_waddr  = slot_q;
				end
			end
			smf_pkg::ST_UP_END: begin
				mem_ctl.we = 1'b1;
				mem_waddr  = LAST;
			end
			smf_pkg::ST_CHK_DN, smf_pkg::ST_DN: begin
				if (dn_lt || state_q == smf_pkg::ST_DN) begin
					mem_ctl.we = 1'b1;
					mem_wdata  = dn_lt ? rd : c_q;
					c_d        = dn_lt ? c_q : rd;
					k_d        = k_q - ONE;
					mem_ctl.re = !dn_last;
					mem_raddr  = k_q - TWO;
				end else begin
					mem_ctl.we = 1'b1;
					mem_waddr  = slot_q;
				end
			end
			smf_pkg::ST_DN_END: begin
				mem_ctl.we = 1'b1;
				mem_waddr  = '0;
			end
			smf_pkg::ST_MID: begin
				mem_ctl.re = 1'b1;
				mem_raddr  = MID;
			end
			smf_pkg::ST_CAP: begin
				mem_ctl = '0;
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smf_pkg::ST_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pos_q <= (pos_q == LAST) ? '0 : pos_q + ONE;
			end
			if (cap) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		c_q <= c_d;
		k_q <= k_d;
		if (accept) begin
			slot_q <= pos_q;
		end
		if (cap) begin
			median_q <= rd;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

endmodule

// ===== design/sliding_median_filter_top.sv =====
// Top level of the sliding median filter.
//
// Input channel: in_valid / in_ready with the signed sample. Output channel:
// out_valid / out_ready with the signed median, one result beat per input beat.
// Each sample overwrites the window slot at the write position, then one
// compare-swap pass runs up or down the window, one slot per cycle through
// the single read and single write port of the window memory, and the middle
// slot is read out.
// From an input beat, the sequencer reads the neighbor slot, tests it, runs
// the compare-swap pass when the sample is out of order, reads the middle
// slot and captures it in the output register. The block takes one sample at
// a time and takes no new sample until its result is in the output register.
// The result sits in an output register; a new sample is accepted while it
// waits. When the receiver stalls with a result already waiting, the next
// result is held back and no further sample is taken until it moves.
// Reset clears the write position and marks every slot as zero; no clearing
// pass is needed and samples are accepted right after reset.
module sliding_median_filter_top #(
	parameter int WINDOW       = smf_pkg::WINDOW_DEF,
	parameter int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] median
);

	localparam int IDX_W = $clog2(WINDOW);

	smf_pkg::mem_ctl_t       mem_ctl;
	logic [IDX_W-1:0]        mem_waddr;
	logic [IDX_W-1:0]        mem_raddr;
	logic [SAMPLE_WIDTH-1:0] mem_wdata;
	logic [SAMPLE_WIDTH-1:0] mem_rdata;

	smf_ctrl #(
		.WINDOW       (WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.mem_ctl   (mem_ctl),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	smf_mem #(
		.WINDOW       (WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

endmodule

// ===== design/smf_checker.sv =====
// Port-level checks for the sliding median filter, bound to the top level.
module smf_checker #(
	parameter int SAMPLE_WIDTH = smf_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [SAMPLE_WIDTH-1:0] sample,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] median
);

	a_reset_out: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result beat shown during reset");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input beat taken while a sample is in flight");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
		else $error("waiting input beat dropped or changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median))
		else $error("stalled result beat dropped or changed");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result beat appeared with no sample in flight");

endmodule

bind sliding_median_filter_top smf_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_smf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.sample    (sample),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.median    (median)
);
